>>> src/dtr_pkg.sv
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared types and constants for the DNS TTL rewriter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtr_pkg;

    localparam int BYTE_W  = 8;
    localparam int TTL_W   = 32;
    localparam int COUNT_W = 18;
    localparam int USER_W  = COUNT_W + 1;   // status + patched count

    localparam logic [15:0] TYPE_OPT = 16'd41;

    // Byte positions inside the fixed-size parts of the message
    localparam logic [3:0] POS_QD_HI   = 4'd4;
    localparam logic [3:0] POS_QD_LO   = 4'd5;
    localparam logic [3:0] POS_HDR_END = 4'd11;
    localparam logic [3:0] POS_QFIX_END = 4'd3;
    localparam logic [3:0] POS_TYPE_HI = 4'd0;
    localparam logic [3:0] POS_TYPE_LO = 4'd1;
    localparam logic [3:0] POS_TTL0    = 4'd4;
    localparam logic [3:0] POS_TTL1    = 4'd5;
    localparam logic [3:0] POS_TTL2    = 4'd6;
    localparam logic [3:0] POS_TTL3    = 4'd7;
    localparam logic [3:0] POS_RDLEN_HI = 4'd8;
    localparam logic [3:0] POS_RFIX_END = 4'd9;

    localparam logic [7:0] PTR_MASK  = 8'hC0;
    localparam logic [7:0] LABEL_MAX = 8'd63;

    // One result item as it leaves the walker
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               out_last;
        logic               status;
        logic [COUNT_W-1:0] patched_count;
    } dtr_result_t;

endpackage

`default_nettype wire

>>> src/dtr_walk.sv
// ----------------------------------------------------------------------------
// dtr_walk
// Message walker: tracks header, question and record structure byte by byte
// and substitutes TTL bytes of non-OPT records.
// ----------------------------------------------------------------------------
`default_nettype none

module dtr_walk (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step,
    input  wire logic [dtr_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                         in_last,
    input  wire logic [dtr_pkg::TTL_W-1:0]    new_ttl,
    output dtr_pkg::dtr_result_t              result
);
    import dtr_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR, PH_QNAME, PH_QPTR, PH_QFIX,
        PH_RNAME, PH_RPTR, PH_RFIX, PH_RDATA,
        PH_DONE, PH_FAIL
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [3:0]          pos_reg,     pos_next;
    logic [15:0]         qleft_reg,   qleft_next;
    logic [COUNT_W-1:0]  rleft_reg,   rleft_next;
    logic [5:0]          label_reg,   label_next;
    logic [15:0]         rtype_reg,   rtype_next;
    logic [15:0]         rdata_reg,   rdata_next;
    logic [7:0]          held_reg,    held_next;
    logic [COUNT_W-1:0]  patch_reg,   patch_next;

    always_comb begin
        logic [7:0]  ob;
        logic [15:0] word;
        ob          = in_byte;
        word        = {held_reg, in_byte};
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        qleft_next  = qleft_reg;
        rleft_next  = rleft_reg;
        label_next  = label_reg;
        rtype_next  = rtype_reg;
        rdata_next  = rdata_reg;
        held_next   = held_reg;
        patch_next  = patch_reg;

        unique case (phase_reg)
            PH_HDR: begin
                if (pos_reg == POS_QD_HI) begin
                    held_next = in_byte;
                end else if (pos_reg == POS_QD_LO) begin
                    qleft_next = word;
                end else if (pos_reg == 4'd6 || pos_reg == 4'd8 || pos_reg == 4'd10) begin
                    held_next = in_byte;
                end else if (pos_reg == 4'd7 || pos_reg == 4'd9 || pos_reg == 4'd11) begin
                    rleft_next = rleft_reg + {2'b00, word};
                end
                if (pos_reg >= POS_HDR_END) begin
                    pos_next = '0;
                    if (qleft_next != '0)      phase_next = PH_QNAME;
                    else if (rleft_next != '0) phase_next = PH_RNAME;
                    else                       phase_next = PH_DONE;
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_QNAME, PH_RNAME: begin
                if (label_reg != '0) begin
                    label_next = label_reg - 6'd1;
                end else if ((in_byte & PTR_MASK) == PTR_MASK) begin
                    phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_RPTR;
                end else if (in_byte == 8'd0) begin
                    phase_next = (phase_reg == PH_QNAME) ? PH_QFIX : PH_RFIX;
                    pos_next   = '0;
                end else if (in_byte > LABEL_MAX) begin
                    phase_next = PH_FAIL;
                end else begin
                    label_next = in_byte[5:0];
                end
            end
            PH_QPTR: begin
                phase_next = PH_QFIX;
                pos_next   = '0;
            end
            PH_RPTR: begin
                phase_next = PH_RFIX;
                pos_next   = '0;
            end
            PH_QFIX: begin
                if (pos_reg >= POS_QFIX_END) begin
                    pos_next   = '0;
                    qleft_next = qleft_reg - 16'd1;
                    if (qleft_next != '0)      phase_next = PH_QNAME;
                    else if (rleft_reg != '0)  phase_next = PH_RNAME;
                    else                       phase_next = PH_DONE;
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_RFIX: begin
                if (pos_reg == POS_TYPE_HI || pos_reg == POS_RDLEN_HI) begin
                    held_next = in_byte;
                end else if (pos_reg == POS_TYPE_LO) begin
                    rtype_next = word;
                end else if (rtype_reg != TYPE_OPT) begin
                    // TTL goes out big-endian
                    case (pos_reg)
                        POS_TTL0: ob = new_ttl[31:24];
                        POS_TTL1: ob = new_ttl[23:16];
                        POS_TTL2: ob = new_ttl[15:8];
                        POS_TTL3: begin
                            ob         = new_ttl[7:0];
                            patch_next = patch_reg + COUNT_W'(1);
                        end
                        default: ob = in_byte;
                    endcase
                end
                if (pos_reg >= POS_RFIX_END) begin
                    rdata_next = word;
                    pos_next   = '0;
                    if (word == '0) begin
                        rleft_next = rleft_reg - COUNT_W'(1);
                        phase_next = (rleft_next != '0) ? PH_RNAME : PH_DONE;
                    end else begin
                        phase_next = PH_RDATA;
                    end
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_RDATA: begin
                rdata_next = rdata_reg - 16'd1;
                if (rdata_next == '0) begin
                    rleft_next = rleft_reg - COUNT_W'(1);
                    phase_next = (rleft_next != '0) ? PH_RNAME : PH_DONE;
                end
            end
            default: begin
            end
        endcase

        result.out_byte      = ob;
        result.out_last      = in_last;
        result.status        = in_last && (phase_next != PH_DONE);
        result.patched_count = (in_last && phase_next == PH_DONE) ? patch_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            pos_reg   <= '0;
            qleft_reg <= '0;
            rleft_reg <= '0;
            label_reg <= '0;
            rtype_reg <= '0;
            rdata_reg <= '0;
            held_reg  <= '0;
            patch_reg <= '0;
        end else if (step) begin
            if (in_last) begin
                // next byte opens a new message
                phase_reg <= PH_HDR;
                pos_reg   <= '0;
                qleft_reg <= '0;
                rleft_reg <= '0;
                label_reg <= '0;
                rtype_reg <= '0;
                rdata_reg <= '0;
                held_reg  <= '0;
                patch_reg <= '0;
            end else begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                qleft_reg <= qleft_next;
                rleft_reg <= rleft_next;
                label_reg <= label_next;
                rtype_reg <= rtype_next;
                rdata_reg <= rdata_next;
                held_reg  <= held_next;
                patch_reg <= patch_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/dns_ttl_rewriter_core.sv
// ----------------------------------------------------------------------------
// dns_ttl_rewriter_core
// Streaming DNS TTL rewriter: passes a message through byte by byte and
// overwrites the TTL of every non-OPT resource record with new_ttl.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                                    Handshake
// s_axis    in   tdata = msg_byte, tlast = last_byte        s_tvalid/s_tready
// m_axis    out  tdata = out_byte, tlast = out_last,        m_tvalid/m_tready
//                tuser = {patched_count, status}
// cfg       in   cfg_data = new_ttl                         cfg_valid/cfg_ready
//
// One item per cycle sustained while m_tready is high; data passes through the
// input register, then the result register. The walker state advances when
// the item in the input register moves into the result register. A stall on
// m_tready holds the result register and, one item later, the input register;
// s_tready drops only when both are full. Reset (aresetn low, synchronous)
// empties both registers, returns the walker to the header and sets new_ttl to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_ttl_rewriter_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dtr_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] msg_byte
    input  wire logic                          s_tlast,
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dtr_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] out_byte
    output logic                               m_tlast,
    output logic [dtr_pkg::USER_W-1:0]         m_tuser,   // [0] status, [18:1] patched_count
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dtr_pkg::TTL_W-1:0]     cfg_data   // [31:0] new_ttl
);
    import dtr_pkg::*;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_last_reg;
    logic               out_valid_reg;
    dtr_result_t        out_reg;
    dtr_result_t        walk_result;
    logic [TTL_W-1:0]   new_ttl_reg;
    logic               out_ready;
    logic               advance;

    // result register can load when empty or draining this cycle
    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    dtr_walk u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .in_byte  (in_byte_reg),
        .in_last  (in_last_reg),
        .new_ttl  (new_ttl_reg),
        .result   (walk_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            new_ttl_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                new_ttl_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_reg <= walk_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tlast  = out_reg.out_last;
    assign m_tuser  = {out_reg.patched_count, out_reg.status};

endmodule

`default_nettype wire

>>> verif/dns_ttl_rewriter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_ttl_rewriter_core_tb
// Streams DNS messages through the TTL rewriter and checks every output byte,
// last flag, status and patch count against a byte-level walker kept here.
// Most messages are well formed with random names, pointers and record types;
// the rest are truncated, carry bad label bytes, or are plain noise. new_ttl
// is changed between phases while the core is idle.
// ----------------------------------------------------------------------------

module dns_ttl_rewriter_core_tb;
    import dtr_pkg::*;

    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } feed_item_t;

    typedef enum logic [3:0] {
        W_HDR, W_QNAME, W_QPTR, W_QFIX, W_RNAME, W_RPTR, W_RFIX, W_RDATA, W_DONE, W_FAIL
    } walk_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [BYTE_W-1:0]   m_tdata;
    logic                m_tlast;
    logic [USER_W-1:0]   m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TTL_W-1:0]    cfg_data  = '0;

    dns_ttl_rewriter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Walker state mirrored from the block
    // ------------------------------------------------------------------
    walk_t              walk;
    logic [3:0]         pos;
    logic [15:0]        q_left;
    logic [COUNT_W-1:0] rr_left;
    logic [5:0]         lbl_left;
    logic [15:0]        rtype;
    logic [15:0]        rd_left;
    logic [7:0]         hi;
    logic [COUNT_W-1:0] patched;
    logic [TTL_W-1:0]   ttl_reg;

    dtr_result_t rewritten_q[$];
    feed_item_t  msg_feed[$];
    logic [7:0]  msg_buf[$];

    int  errors = 0;
    int  fed_items = 0;
    bit  in_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  rx_tick = 0;
    int  rx_mode = 0;
    int  stall_asks = 0;
    int  stall_seen = 0;
    int  stall_left = 0;

    task automatic clear_walk();
        walk = W_HDR;
        pos = '0;
        q_left = '0;
        rr_left = '0;
        lbl_left = '0;
        rtype = '0;
        rd_left = '0;
        hi = '0;
        patched = '0;
    endtask

    task automatic next_section();
        if (q_left != 0) walk = W_QNAME;
        else if (rr_left != 0) walk = W_RNAME;
        else walk = W_DONE;
    endtask

    task automatic close_record();
        rr_left = rr_left - COUNT_W'(1);
        walk = (rr_left != 0) ? W_RNAME : W_DONE;
    endtask

    // one byte of an owner name, shared by questions and records
    task automatic name_step(input logic [7:0] b, input walk_t ptr_st, input walk_t fix_st);
        if (lbl_left != 0) begin
            lbl_left = lbl_left - 6'd1;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
            walk = ptr_st;
        end else if (b == 8'd0) begin
            walk = fix_st;
            pos = '0;
        end else if (b > LABEL_MAX) begin
            walk = W_FAIL;
        end else begin
            lbl_left = b[5:0];
        end
    endtask

    // advance the walker by one accepted byte and queue the output it implies
    task automatic walk_byte(input logic [7:0] b, input logic lst);
        dtr_result_t r;
        int          sh;
        r = '0;
        r.out_byte = b;
        r.out_last = lst;
        case (walk)
            W_HDR: begin
                if (pos == POS_QD_HI) hi = b;
                else if (pos == POS_QD_LO) q_left = {hi, b};
                else if (pos >= 4'd6) begin
                    // counts at 6..11: even position holds the high byte
                    if (!pos[0]) hi = b;
                    else rr_left = rr_left + {2'b00, hi, b};
                end
                if (pos >= POS_HDR_END) begin
                    pos = '0;
                    next_section();
                end else begin
                    pos = pos + 4'd1;
                end
            end
            W_QNAME: name_step(b, W_QPTR, W_QFIX);
            W_QPTR: begin
                walk = W_QFIX;
                pos = '0;
            end
            W_QFIX: begin
                if (pos >= POS_QFIX_END) begin
                    pos = '0;
                    q_left = q_left - 16'd1;
                    next_section();
                end else begin
                    pos = pos + 4'd1;
                end
            end
            W_RNAME: name_step(b, W_RPTR, W_RFIX);
            W_RPTR: begin
                walk = W_RFIX;
                pos = '0;
            end
            W_RFIX: begin
                if (pos == POS_TYPE_HI || pos == POS_RDLEN_HI) begin
                    hi = b;
                end else if (pos == POS_TYPE_LO) begin
                    rtype = {hi, b};
                end else if (pos >= POS_TTL0 && pos <= POS_TTL3 && rtype != TYPE_OPT) begin
                    sh = 8 * int'(POS_TTL3 - pos);
                    r.out_byte = ttl_reg[sh +: 8];
                    if (pos == POS_TTL3) patched = patched + COUNT_W'(1);
                end
                if (pos >= POS_RFIX_END) begin
                    rd_left = {hi, b};
                    pos = '0;
                    if (rd_left == 0) close_record();
                    else walk = W_RDATA;
                end else begin
                    pos = pos + 4'd1;
                end
            end
            W_RDATA: begin
                rd_left = rd_left - 16'd1;
                if (rd_left == 0) close_record();
            end
            default: ;
        endcase
        if (lst) begin
            if (walk == W_DONE) r.patched_count = patched;
            else r.status = 1'b1;
            clear_walk();
        end
        rewritten_q = {rewritten_q, r};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 50)
            $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on input accept, compare on output accept
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        dtr_result_t want;
        in_taken = aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            clear_walk();
            ttl_reg = '0;
        end else begin
            if (cfg_valid && cfg_ready) ttl_reg = cfg_data;
            if (in_taken) walk_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (rewritten_q.size() == 0) begin
                    report_mismatch("unexpected item", {23'd0, m_tlast, m_tdata}, '0);
                end else begin
                    want = rewritten_q.pop_front();
                    if (m_tdata !== want.out_byte)
                        report_mismatch("out_byte", 32'(m_tdata), 32'(want.out_byte));
                    if (m_tlast !== want.out_last)
                        report_mismatch("out_last", 32'(m_tlast), 32'(want.out_last));
                    if (m_tuser[0] !== want.status)
                        report_mismatch("status", 32'(m_tuser[0]), 32'(want.status));
                    if (m_tuser[USER_W-1:1] !== want.patched_count)
                        report_mismatch("patched_count", 32'(m_tuser[USER_W-1:1]),
                                        32'(want.patched_count));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        feed_item_t nxt;
        logic       v_n;
        logic [7:0] d_n;
        logic       l_n;
        v_n = s_tvalid;
        d_n = s_tdata;
        l_n = s_tlast;
        if (!s_tvalid || in_taken) begin
            v_n = 1'b0;
            d_n = 8'($urandom);
            l_n = 1'($urandom);
            if (gap_left > 0) begin
                gap_left--;
            end else if (msg_feed.size() > 0) begin
                nxt = msg_feed.pop_front();
                v_n = 1'b1;
                d_n = nxt.data;
                l_n = nxt.last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_tvalid <= v_n;
        s_tdata  <= d_n;
        s_tlast  <= l_n;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches among four modes; long hold on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        logic rdy;
        rx_tick++;
        if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
        if (stall_seen != stall_asks) begin
            stall_seen = stall_asks;
            stall_left = 64;
        end
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = (rx_tick % 4) != 3;
                default: rdy = ($urandom_range(0, 4) == 0);
            endcase
        end
        m_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] v);
        msg_buf = {msg_buf, v};
    endtask

    task automatic put16(input logic [15:0] v);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
    endtask

    task automatic put_name(input bit bad);
        int nlab;
        int len;
        nlab = $urandom_range(0, 3);
        for (int i = 0; i < nlab; i++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
            add_byte(8'(len));
            for (int j = 0; j < len; j++) add_byte(8'($urandom));
        end
        if (bad) begin
            add_byte(8'($urandom_range(64, 191)));
        end else if ($urandom_range(0, 2) == 0) begin
            add_byte(PTR_MASK | 8'($urandom_range(0, 63)));
            add_byte(8'($urandom));
        end else begin
            add_byte(8'd0);
        end
    endtask

    task automatic put_record(input bit bad, input bit long_rdata);
        int rdlen;
        put_name(bad);
        case ($urandom_range(0, 4))
            0:       put16(16'h0001);
            1:       put16(TYPE_OPT);
            2:       put16({8'h01, TYPE_OPT[7:0]});   // low byte alone looks like OPT
            3:       put16({TYPE_OPT[7:0], 8'h00});
            default: put16(16'($urandom));
        endcase
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'($urandom));
        if (long_rdata) begin
            rdlen = $urandom_range(256, 65535);
            put16(16'(rdlen));
            for (int i = $urandom_range(0, 10); i > 0; i--) add_byte(8'($urandom));
        end else begin
            rdlen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            put16(16'(rdlen));
            for (int i = 0; i < rdlen; i++) add_byte(8'($urandom));
        end
    endtask

    // whole message; with bad set, one name (if any) carries an illegal label byte
    task automatic build_message(input bit bad);
        int qd;
        int an;
        int ns;
        int ar;
        int bad_idx;
        int idx;
        msg_buf.delete();
        qd = $urandom_range(0, 2);
        an = $urandom_range(0, 3);
        ns = $urandom_range(0, 2);
        ar = $urandom_range(0, 2);
        bad_idx = (bad && qd + an + ns + ar > 0) ? $urandom_range(0, qd + an + ns + ar - 1) : -1;
        idx = 0;
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'(qd));
        put16(16'(an));
        put16(16'(ns));
        put16(16'(ar));
        for (int i = 0; i < qd; i++) begin
            put_name(idx == bad_idx);
            idx++;
            put16(16'($urandom));
            put16(16'($urandom));
        end
        for (int i = 0; i < an + ns + ar; i++) begin
            put_record(idx == bad_idx, 1'b0);
            idx++;
        end
        if ($urandom_range(0, 3) == 0)
            for (int i = $urandom_range(1, 6); i > 0; i--) add_byte(8'($urandom));
    endtask

    // queue the first n bytes of msg_buf, last flag on the final one
    task automatic ship(input int n);
        for (int i = 0; i < n; i++)
            msg_feed = {msg_feed, feed_item_t'{msg_buf[i], (i == n - 1)}};
        fed_items += n;
    endtask

    task automatic ship_cut();
        ship((msg_buf.size() > 1) ? $urandom_range(1, msg_buf.size() - 1) : msg_buf.size());
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (msg_feed.size() != 0 || s_tvalid || rewritten_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_ttl(input logic [TTL_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_data  <= TTL_W'($urandom);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [TTL_W-1:0] ttl_plan[5];
        clear_walk();
        ttl_reg = '0;
        ttl_plan[0] = '1;
        ttl_plan[1] = '0;
        ttl_plan[2] = TTL_W'($urandom);
        ttl_plan[3] = 32'h0102_0304;
        ttl_plan[4] = TTL_W'($urandom);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, with the reset TTL: short message
        msg_buf = '{8'h00, 8'hFF};
        ship(msg_buf.size());
        // one OPT record behind a compression pointer, all counts at the extremes of use
        msg_buf = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h01, 8'hC0, 8'h0C, 8'h00, 8'h29, 8'h10, 8'h00, 8'h12, 8'h34,
                    8'h56, 8'h78, 8'h00, 8'h00};
        ship(msg_buf.size());
        // bad label byte in the question name
        msg_buf = '{8'h12, 8'h34, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h40, 8'h00};
        ship(msg_buf.size());

        foreach (ttl_plan[p]) begin
            wait_idle();
            write_ttl(ttl_plan[p]);
            fed_items = 0;
            while (fed_items < PHASE_ITEMS) begin
                case ($urandom_range(0, 19))
                    14, 15: begin
                        build_message(1'b0);
                        ship_cut();
                    end
                    16: begin
                        build_message(1'b1);
                        ship(msg_buf.size());
                    end
                    17: begin
                        msg_buf.delete();
                        for (int i = $urandom_range(1, 20); i > 0; i--)
                            add_byte(8'($urandom));
                        ship(msg_buf.size());
                    end
                    18: begin
                        // huge counts and a long rdata, always cut short
                        msg_buf.delete();
                        put16(16'($urandom));
                        put16(16'($urandom));
                        put16(16'd0);
                        put16(16'hFFFF);
                        put16(16'($urandom));
                        put16(16'hFFFF);
                        put_record(1'b0, 1'b1);
                        ship_cut();
                    end
                    19: begin
                        build_message(1'b1);
                        ship_cut();
                    end
                    default: begin
                        build_message(1'b0);
                        ship(msg_buf.size());
                    end
                endcase
            end
            // hold the receiver while these items are still being offered
            if (p % 2 == 1) stall_asks++;
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
